@@ rtl/pidm_pkg.sv @@
// Shared types and constants for the PID position motor drive.
// Used by pidm_cfg, pidm_serial_mul and pid_position_motor_drive.
// No dependencies.
package pidm_pkg;

  // Field widths.
  localparam int unsigned POS_BITS_DEF  = 16;
  localparam int unsigned GAIN_BITS     = 16;
  localparam int unsigned DIGIT_BITS    = 4;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned DB_BITS       = 8;
  localparam int unsigned LIM_BITS      = 7;
  localparam int unsigned DIR_BITS      = 2;
  localparam int unsigned DUTY_BITS     = 7;
  localparam int unsigned WIDTH_BITS    = 16;

  // Full duty in percent.
  localparam logic [DUTY_BITS-1:0] FullScale = 7'd100;

  // Duty times period stays below 2^23; divide by 100 with a reciprocal.
  localparam int unsigned PROD_BITS   = 23;
  localparam int unsigned RECIP_BITS  = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_BITS-1:0] Div100Recip = 24'd10737419;

  // Register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_DEAD_BAND   = 3'd3,
    REG_INTEG_LIMIT = 3'd4,
    REG_PWM_PERIOD  = 3'd5
  } cfg_reg_e;

  // Drive direction codes.
  typedef enum logic [DIR_BITS-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } drive_dir_e;

  // Register file contents.
  typedef struct packed {
    logic [GAIN_BITS-1:0]  gain_prop;
    logic [GAIN_BITS-1:0]  gain_integ;
    logic [GAIN_BITS-1:0]  gain_deriv;
    logic [DB_BITS-1:0]    dead_band;
    logic [LIM_BITS-1:0]   integ_limit;
    logic [WIDTH_BITS-1:0] pwm_period;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    gain_prop:   16'd256,
    gain_integ:  16'd0,
    gain_deriv:  16'd0,
    dead_band:   8'd5,
    integ_limit: 7'd50,
    pwm_period:  16'd1250
  };

endpackage

@@ rtl/pidm_cfg.sv @@
// Configuration register file of the PID position motor drive.
// Depends on pidm_pkg for the register indexes and the cfg_t layout.
module pidm_cfg import pidm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the index; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GAIN_PROP:   cfg_q.gain_prop   <= cfg_wdata_i;
        REG_GAIN_INTEG:  cfg_q.gain_integ  <= cfg_wdata_i;
        REG_GAIN_DERIV:  cfg_q.gain_deriv  <= cfg_wdata_i;
        REG_DEAD_BAND:   cfg_q.dead_band   <= cfg_wdata_i[DB_BITS-1:0];
        REG_INTEG_LIMIT: cfg_q.integ_limit <= cfg_wdata_i[LIM_BITS-1:0];
        REG_PWM_PERIOD:  cfg_q.pwm_period  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/pidm_serial_mul.sv @@
// Digit-serial multiplier: signed operand times unsigned 16-bit operand,
// one 4-bit digit of the unsigned operand per cycle. Depends on pidm_pkg.
module pidm_serial_mul import pidm_pkg::*; #(
  parameter  int unsigned AW = 34,
  localparam int unsigned PW = AW + GAIN_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [GAIN_BITS-1:0] b_i,
  output logic                 done_o,
  output logic signed [PW-1:0] prod_o
);

  localparam int unsigned NDIG     = GAIN_BITS / DIGIT_BITS;
  localparam int unsigned CNT_BITS = $clog2(NDIG + 1);

  logic signed [PW-1:0]           a_sh_q;
  logic [GAIN_BITS-1:0]           b_sh_q;
  logic signed [PW-1:0]           acc_q;
  logic [CNT_BITS-1:0]            cnt_q;
  logic                           done_q;
  logic signed [PW+DIGIT_BITS:0]  pp;

  // Partial product of the shifted operand and the current digit.
  assign pp = a_sh_q * $signed({1'b0, b_sh_q[DIGIT_BITS-1:0]});

  // Load on start, then one digit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_sh_q <= '0;
      b_sh_q <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_sh_q <= PW'(a_i);
        b_sh_q <= b_i;
        acc_q  <= '0;
        cnt_q  <= CNT_BITS'(NDIG);
      end else if (cnt_q != '0) begin
        acc_q  <= acc_q + pp[PW-1:0];
        a_sh_q <= a_sh_q <<< DIGIT_BITS;
        b_sh_q <= b_sh_q >> DIGIT_BITS;
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_BITS'(1));
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ rtl/pid_position_motor_drive.sv @@
// PID position controller with integral clamp for a DC motor drive.
// Depends on pidm_pkg, pidm_cfg and pidm_serial_mul.
//
//  Channel | Direction | Handshake                  | Word
//  s_axis  | in        | s_axis_tvalid/tready       | target, measured position
//  m_axis  | out       | m_axis_tvalid/tready       | dir, duty, width, update, error
//  cfg     | in        | cfg_valid_i/cfg_ready_o    | register index, write data
//
// A new word is accepted only after the previous one has entered the output
// register. The shared digit-serial multiplier forms the P, D, I and pulse
// width products in turn, one 4-bit digit at a time; the integral step is
// skipped when the P term is at or above full scale.
// Reset clears the controller state and loads the register defaults.
// A finished word waits in the output register; a stall on m_axis holds the
// block after its computation until the word is taken.
module pid_position_motor_drive import pidm_pkg::*; #(
  parameter  int unsigned POSITION_BITS  = POS_BITS_DEF,
  localparam int unsigned ERR_BITS       = POSITION_BITS + 1,
  localparam int unsigned IN_TDATA_BITS  = ((2 * POSITION_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_FIELD_BITS = DIR_BITS + DUTY_BITS + WIDTH_BITS + 1 + ERR_BITS,
  localparam int unsigned OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // target_position, measured_position
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // drive_dir, duty_percent, pulse_width, pulse_update, pos_error
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  localparam int unsigned AW        = (ERR_BITS + 1 > 32) ? ERR_BITS + 1 : 32;
  localparam int unsigned PW        = AW + GAIN_BITS;
  localparam int unsigned SUM_BITS  = ((ERR_BITS > 32) ? ERR_BITS : 32) + 1;
  localparam int unsigned TOT_BITS  = PW + 2;
  localparam int unsigned ILIM_BITS = LIM_BITS + 9;

  localparam logic signed [SUM_BITS-1:0] SumMax    = SUM_BITS'(33'sh0_7fff_ffff);
  localparam logic signed [SUM_BITS-1:0] SumMin    = -SumMax - 1;
  localparam logic signed [PW-1:0]       PropFull  = PW'(25600);
  localparam logic signed [TOT_BITS-1:0] RoundBias = TOT_BITS'(255);
  localparam logic signed [TOT_BITS-1:0] TotFull   = TOT_BITS'(100);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROP, ST_DERIV, ST_INTEG, ST_TOTAL, ST_DUTY, ST_WIDTH, ST_OUT
  } state_e;

  cfg_t cfg;

  state_e                      state_q;
  logic signed [ERR_BITS-1:0]  err_q;
  logic signed [ERR_BITS:0]    diff_q;
  logic signed [ERR_BITS-1:0]  prev_err_q;
  logic signed [PW-1:0]        p_q;
  logic signed [PW-1:0]        d_q;
  logic signed [ILIM_BITS-1:0] i_q;
  logic                        use_i_q;
  logic signed [31:0]          cand_sum_q;
  logic signed [31:0]          sum_q;
  logic signed [TOT_BITS-1:0]  tot_q;
  logic [DUTY_BITS-1:0]        prev_duty_q;
  logic [PROD_BITS-1:0]        wprod_q;
  logic [DIR_BITS-1:0]         dir_q;
  logic [DUTY_BITS-1:0]        duty_q;
  logic                        upd_q;
  logic                        mul_start_q;
  logic signed [AW-1:0]        mul_a_q;
  logic [GAIN_BITS-1:0]        mul_b_q;
  logic                        out_valid_q;
  logic [DIR_BITS-1:0]         out_dir_q;
  logic [DUTY_BITS-1:0]        out_duty_q;
  logic [WIDTH_BITS-1:0]       out_width_q;
  logic                        out_upd_q;
  logic signed [ERR_BITS-1:0]  out_err_q;

  logic                          mul_done;
  logic signed [PW-1:0]          mul_prod;
  logic [POSITION_BITS-1:0]      target;
  logic [POSITION_BITS-1:0]      measured;
  logic signed [ERR_BITS-1:0]    err_in;
  logic signed [SUM_BITS-1:0]    sum_wide;
  logic signed [31:0]            sat_sum;
  logic signed [ILIM_BITS-1:0]   ilim;
  logic signed [PW-1:0]          ilim_wide;
  logic signed [TOT_BITS-1:0]    tot_sel;
  logic signed [TOT_BITS-1:0]    tot_int;
  logic signed [TOT_BITS-1:0]    tot_mag;
  logic [DUTY_BITS-1:0]          duty_new;
  logic [ERR_BITS-1:0]           mag_err;
  logic                          in_db;
  logic [PROD_BITS+RECIP_BITS-1:0] wscaled;
  logic                          accept;

  pidm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pidm_serial_mul #(.AW(AW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Input unpacking and the position error.
  assign target        = s_axis_tdata[POSITION_BITS-1:0];
  assign measured      = s_axis_tdata[2*POSITION_BITS-1:POSITION_BITS];
  assign err_in        = $signed({1'b0, target}) - $signed({1'b0, measured});
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Saturating error sum candidate.
  assign sum_wide = SUM_BITS'(sum_q) + SUM_BITS'(err_q);
  always_comb begin
    if (sum_wide > SumMax) begin
      sat_sum = 32'sh7fff_ffff;
    end else if (sum_wide < SumMin) begin
      sat_sum = 32'sh8000_0000;
    end else begin
      sat_sum = sum_wide[31:0];
    end
  end

  // Integral limit at 8 fraction bits.
  assign ilim      = $signed({1'b0, cfg.integ_limit, 8'h00});
  assign ilim_wide = PW'(ilim);

  // Truncate toward zero, take the magnitude and cap at full scale.
  assign tot_sel  = tot_q[TOT_BITS-1] ? (tot_q + RoundBias) : tot_q;
  assign tot_int  = tot_sel >>> 8;
  assign tot_mag  = tot_int[TOT_BITS-1] ? -tot_int : tot_int;
  assign duty_new = (tot_mag > TotFull) ? FullScale : tot_mag[DUTY_BITS-1:0];

  // Dead band test on the error magnitude.
  assign mag_err = err_q[ERR_BITS-1] ? ERR_BITS'(-err_q) : ERR_BITS'(err_q);
  assign in_db   = mag_err <= ERR_BITS'(cfg.dead_band);

  // Pulse width: divide by 100 through the reciprocal.
  assign wscaled = wprod_q * Div100Recip;

  // Sequencer, controller state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      err_q       <= '0;
      diff_q      <= '0;
      prev_err_q  <= '0;
      p_q         <= '0;
      d_q         <= '0;
      i_q         <= '0;
      use_i_q     <= 1'b0;
      cand_sum_q  <= '0;
      sum_q       <= '0;
      tot_q       <= '0;
      prev_duty_q <= '0;
      wprod_q     <= '0;
      dir_q       <= DIR_STOP;
      duty_q      <= '0;
      upd_q       <= 1'b0;
      mul_start_q <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      out_valid_q <= 1'b0;
      out_dir_q   <= DIR_STOP;
      out_duty_q  <= '0;
      out_width_q <= '0;
      out_upd_q   <= 1'b0;
      out_err_q   <= '0;
    end else begin
      // A taken word frees the output register unless a new word replaces it.
      if (out_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          mul_start_q <= accept;
          if (accept) begin
            err_q       <= err_in;
            diff_q      <= (ERR_BITS+1)'(err_in) - (ERR_BITS+1)'(prev_err_q);
            mul_a_q     <= AW'(err_in);
            mul_b_q     <= cfg.gain_prop;
            state_q     <= ST_PROP;
          end
        end
        ST_PROP: begin
          mul_start_q <= mul_done;
          if (mul_done) begin
            p_q         <= mul_prod;
            use_i_q     <= (mul_prod < PropFull) && (mul_prod > -PropFull);
            mul_a_q     <= AW'(diff_q);
            mul_b_q     <= cfg.gain_deriv;
            state_q     <= ST_DERIV;
          end
        end
        ST_DERIV: begin
          mul_start_q <= mul_done && use_i_q;
          if (mul_done) begin
            d_q <= mul_prod;
            if (use_i_q) begin
              cand_sum_q  <= sat_sum;
              mul_a_q     <= AW'(sat_sum);
              mul_b_q     <= cfg.gain_integ;
              state_q     <= ST_INTEG;
            end else begin
              i_q     <= '0;
              state_q <= ST_TOTAL;
            end
          end
        end
        ST_INTEG: begin
          mul_start_q <= 1'b0;
          if (mul_done) begin
            if (mul_prod > ilim_wide) begin
              i_q <= ilim;
            end else if (mul_prod < -ilim_wide) begin
              i_q <= -ilim;
            end else begin
              i_q   <= mul_prod[ILIM_BITS-1:0];
              sum_q <= cand_sum_q;
            end
            state_q <= ST_TOTAL;
          end
        end
        ST_TOTAL: begin
          mul_start_q <= 1'b0;
          tot_q   <= TOT_BITS'(p_q) + TOT_BITS'(d_q) + TOT_BITS'(i_q);
          state_q <= ST_DUTY;
        end
        ST_DUTY: begin
          prev_err_q <= err_q;
          if (in_db) begin
            dir_q   <= DIR_STOP;
            duty_q  <= '0;
            upd_q   <= 1'b0;
            sum_q   <= '0;
            mul_b_q <= '0;
          end else begin
            dir_q       <= tot_int[TOT_BITS-1] ? DIR_REV : DIR_FWD;
            duty_q      <= duty_new;
            upd_q       <= (duty_new != prev_duty_q);
            prev_duty_q <= duty_new;
            mul_b_q     <= GAIN_BITS'(duty_new);
          end
          mul_a_q     <= AW'(cfg.pwm_period);
          mul_start_q <= 1'b1;
          state_q     <= ST_WIDTH;
        end
        ST_WIDTH: begin
          mul_start_q <= 1'b0;
          if (mul_done) begin
            wprod_q <= mul_prod[PROD_BITS-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          mul_start_q <= 1'b0;
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_dir_q   <= dir_q;
            out_duty_q  <= duty_q;
            out_width_q <= wscaled[RECIP_SHIFT +: WIDTH_BITS];
            out_upd_q   <= upd_q;
            out_err_q   <= err_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          mul_start_q <= 1'b0;
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_BITS'({out_err_q, out_upd_q, out_width_q,
                                          out_duty_q, out_dir_q});

`ifndef ASSERT_OFF
  a_accept_starts_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_PROP) else $error("accepted word did not start P product");
  a_stop_is_idle_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_dir_q == DIR_STOP) |-> (out_duty_q == '0 && out_width_q == '0))
    else $error("stopped drive with nonzero duty or width");
  a_duty_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_duty_q <= FullScale) else $error("duty above full scale");
  a_integ_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TOTAL |-> (i_q <= ilim && i_q >= -ilim))
    else $error("integral term outside its limit");
`endif

endmodule
